// ===== sv/bcc_pkg.sv =====
// Shared constants and types for the barycentric coefficient unit.
`timescale 1ns / 1ps

package bcc_pkg;

    // Output weight format
    localparam int WEIGHT_WIDTH = 20;
    localparam int WEIGHT_MAX   = 2 ** (WEIGHT_WIDTH - 1) - 1;

    // Quotient bits kept by the divider row; the top bit flags overflow
    localparam int QUOT_BITS    = WEIGHT_WIDTH + 1;

    // Number of input coordinates: A, B, C, P, three axes each
    localparam int NUM_COORDS   = 12;

    // Tag that travels alongside each request through the pipe
    typedef struct packed {
        logic       vld;
        logic       deg;
        logic [2:0] neg;
    } t_tag;

endpackage

// ===== sv/barycentric_coefficients_3d_unit.sv =====
// Top level of the barycentric coefficient unit for 3D triangles.
//
// Usage: present vertices A, B, C and point P (signed, 8 fraction bits) on
// the request channel with i_valid; a request is taken on a rising edge where
// i_valid is high and o_stall is low. One result per request appears on
// o_valid with weights for A, B and C (signed, WEIGHT_FRAC_BITS fraction bits,
// rounded to nearest with ties away from zero, saturated to 20 bits) and a
// degenerate flag; a zero-area triangle gives zero weights with the flag set.
// Pipeline: 7 front stages (differences, cross products, split multiplies,
// partial-product sums, dot sums, sign split and dividend set-up), then 22
// divider cells, one per quotient bit incl. the overflow bit, then the output
// register. Throughput: one request per cycle without back-pressure, set by
// the row of divider cells, each of which hands its partial remainder on.
// Each stage holds its own valid bit and advances when its successor is empty
// or moving, so bubbles close up while the receiver stalls and new requests
// are still taken until every stage is full; o_stall then rises.
// Reset (i_rst_n low, synchronous) empties the pipe; data registers are not reset.
`timescale 1ns / 1ps

module barycentric_coefficients_3d_unit import bcc_pkg::*; #(
    parameter int COORD_WIDTH      = 16,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [COORD_WIDTH-1:0]  i_vertex_a_x,
    input  logic signed [COORD_WIDTH-1:0]  i_vertex_a_y,
    input  logic signed [COORD_WIDTH-1:0]  i_vertex_a_z,
    input  logic signed [COORD_WIDTH-1:0]  i_vertex_b_x,
    input  logic signed [COORD_WIDTH-1:0]  i_vertex_b_y,
    input  logic signed [COORD_WIDTH-1:0]  i_vertex_b_z,
    input  logic signed [COORD_WIDTH-1:0]  i_vertex_c_x,
    input  logic signed [COORD_WIDTH-1:0]  i_vertex_c_y,
    input  logic signed [COORD_WIDTH-1:0]  i_vertex_c_z,
    input  logic signed [COORD_WIDTH-1:0]  i_point_x,
    input  logic signed [COORD_WIDTH-1:0]  i_point_y,
    input  logic signed [COORD_WIDTH-1:0]  i_point_z,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [WEIGHT_WIDTH-1:0] o_weight_a,
    output logic signed [WEIGHT_WIDTH-1:0] o_weight_b,
    output logic signed [WEIGHT_WIDTH-1:0] o_weight_c,
    output logic                           o_degenerate
);

    // Widths of the inner arithmetic, following the coordinate width
    localparam int DW  = COORD_WIDTH + 1;          // edge vector
    localparam int CW  = 2 * DW;                   // cross product component
    localparam int PW  = 2 * CW + 1;               // dot product
    localparam int RW  = PW + WEIGHT_FRAC_BITS + QUOT_BITS + 3;  // partial remainder
    localparam int DVW = PW + 1;                   // divisor, twice n.n
    localparam int NC  = QUOT_BITS + 1;            // divider cells

    logic [NUM_COORDS-1:0][COORD_WIDTH-1:0] coord;

    // Hand-off between neighbouring cells; index 0 is the front's output
    t_tag                        c_tag [NC+1];
    logic [2:0][RW-1:0]          c_rem [NC+1];
    logic [2:0][QUOT_BITS:0]     c_q   [NC+1];
    logic [DVW-1:0]              c_div [NC+1];
    logic                        c_en  [NC+1];
    logic                        front_en;

    logic                           out_en;
    logic [2:0][WEIGHT_WIDTH-1:0]   n_w;
    logic                           r_out_vld;
    logic [2:0][WEIGHT_WIDTH-1:0]   r_w;
    logic                           r_deg;

    assign coord = {i_point_z, i_point_y, i_point_x,
                    i_vertex_c_z, i_vertex_c_y, i_vertex_c_x,
                    i_vertex_b_z, i_vertex_b_y, i_vertex_b_x,
                    i_vertex_a_z, i_vertex_a_y, i_vertex_a_x};

    bcc_front #(
        .COORD_WIDTH      (COORD_WIDTH),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_coord   (coord),
        .o_en      (front_en),
        .i_next_en (c_en[0]),
        .o_tag     (c_tag[0]),
        .o_rem     (c_rem[0]),
        .o_div     (c_div[0])
    );

    assign c_q[0]  = '0;
    assign o_stall = !front_en;

    // Divider row: the first cell tests the overflow bit, the rest settle
    // quotient bits from the top down.
    for (genvar i = 0; i < NC; i++) begin : g_cell
        bcc_div_cell #(
            .RW    (RW),
            .DVW   (DVW),
            .SHIFT (QUOT_BITS - i)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_tag     (c_tag[i]),
            .i_rem     (c_rem[i]),
            .i_q       (c_q[i]),
            .i_div     (c_div[i]),
            .o_en      (c_en[i]),
            .i_next_en (c_en[i+1]),
            .o_tag     (c_tag[i+1]),
            .o_rem     (c_rem[i+1]),
            .o_q       (c_q[i+1]),
            .o_div     (c_div[i+1])
        );
    end

    assign out_en  = !r_out_vld || !i_stall;
    assign c_en[NC] = out_en;

    // Saturate to the signed 20-bit range, restore the sign, and zero the weights of a degenerate triangle.
    always_comb begin
        logic [QUOT_BITS-1:0] lim;
        logic [QUOT_BITS-1:0] m;
        logic [QUOT_BITS-1:0] sv;
        for (int w = 0; w < 3; w++) begin
            lim = c_tag[NC].neg[w] ? QUOT_BITS'(WEIGHT_MAX + 1) : QUOT_BITS'(WEIGHT_MAX);
            if (c_q[NC][w][QUOT_BITS] || (c_q[NC][w][QUOT_BITS-1:0] >= lim)) begin
                m = lim;
            end else begin
                m = c_q[NC][w][QUOT_BITS-1:0];
            end
            sv = c_tag[NC].neg[w] ? (QUOT_BITS'(0) - m) : m;
            n_w[w] = c_tag[NC].deg ? '0 : sv[WEIGHT_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_en) begin
            r_out_vld <= c_tag[NC].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en) begin
            r_w   <= n_w;
            r_deg <= c_tag[NC].deg;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_weight_a   = signed'(r_w[0]);
    assign o_weight_b   = signed'(r_w[1]);
    assign o_weight_c   = signed'(r_w[2]);
    assign o_degenerate = r_deg;

endmodule

// ===== sv/bcc_front.sv =====
// Front pipeline: edge vectors, cross products, dot products, dividend set-up.
`timescale 1ns / 1ps

module bcc_front import bcc_pkg::*; #(
    parameter int COORD_WIDTH      = 16,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    input  logic [NUM_COORDS-1:0][COORD_WIDTH-1:0]      i_coord,
    output logic                                        o_en,
    input  logic                                        i_next_en,
    output t_tag                                        o_tag,
    output logic [2:0][2*(4*COORD_WIDTH+5)+WEIGHT_FRAC_BITS+QUOT_BITS+3-(4*COORD_WIDTH+5)-1:0]
                                                        o_rem,
    output logic [2*(2*(COORD_WIDTH+1))+1:0]            o_div
);

    localparam int DW  = COORD_WIDTH + 1;
    localparam int CW  = 2 * DW;
    localparam int HW  = CW / 2;
    localparam int GW  = CW - HW;
    localparam int PW  = 2 * CW + 1;
    localparam int RW  = PW + WEIGHT_FRAC_BITS + QUOT_BITS + 3;
    localparam int DVW = PW + 1;
    localparam int NS  = 7;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] en;

    logic signed [DW-1:0] a [3];
    logic signed [DW-1:0] b [3];
    logic signed [DW-1:0] c [3];
    logic signed [DW-1:0] p [3];

    logic signed [DW-1:0] r0_ba [3];
    logic signed [DW-1:0] r0_ca [3];
    logic signed [DW-1:0] r0_pa [3];
    logic signed [DW-1:0] r0_pb [3];
    logic signed [DW-1:0] r0_pc [3];

    logic signed [CW-1:0] r1_n  [3];
    logic signed [CW-1:0] r1_sa [3];
    logic signed [CW-1:0] r1_sb [3];
    logic signed [CW-1:0] r1_sc [3];
    logic signed [CW-1:0] s1_v  [4][3];

    logic [4*PW-1:0]      r2_pp [4][3];
    logic                 r2_deg;
    logic signed [PW-1:0] r3_cs [4][3];
    logic                 r3_deg;
    logic signed [PW-1:0] r4_dot [4];
    logic                 r4_deg;
    logic [PW-1:0]        r5_mag [3];
    logic [2:0]           r5_neg;
    logic [PW-1:0]        r5_nn;
    logic                 r5_deg;
    logic [2:0][RW-1:0]   r6_rem;
    logic [2:0]           r6_neg;
    logic [DVW-1:0]       r6_div;
    logic                 r6_deg;

    function automatic logic signed [CW-1:0] xprod(
        input logic signed [DW-1:0] u1, v2, u2, v1
    );
        logic signed [CW-1:0] m1;
        logic signed [CW-1:0] m2;
        m1 = CW'(u1) * CW'(v2);
        m2 = CW'(u2) * CW'(v1);
        return m1 - m2;
    endfunction

    // Four partial products of a CW x CW signed multiply, each sign-extended
    function automatic logic [4*PW-1:0] part(input logic signed [CW-1:0] x, y);
        logic signed [GW-1:0]      xh, yh;
        logic signed [HW:0]        xl, yl;
        logic signed [2*GW-1:0]    hh;
        logic signed [GW+HW:0]     hl, lh;
        logic signed [2*HW+1:0]    ll;
        xh = x[CW-1:HW];
        yh = y[CW-1:HW];
        xl = signed'({1'b0, x[HW-1:0]});
        yl = signed'({1'b0, y[HW-1:0]});
        hh = xh * yh;
        hl = xh * yl;
        lh = xl * yh;
        ll = xl * yl;
        return {PW'(hh), PW'(hl), PW'(lh), PW'(ll)};
    endfunction

    function automatic logic signed [PW-1:0] sum4(input logic [4*PW-1:0] pp);
        logic signed [PW-1:0] hh, hl, lh, ll;
        hh = signed'(pp[4*PW-1:3*PW]);
        hl = signed'(pp[3*PW-1:2*PW]);
        lh = signed'(pp[2*PW-1:PW]);
        ll = signed'(pp[PW-1:0]);
        return (hh <<< (2 * HW)) + ((hl + lh) <<< HW) + ll;
    endfunction

    always_comb begin
        en[NS-1] = !r_vld[NS-1] || i_next_en;
        for (int s = NS - 2; s >= 0; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            a[j] = DW'(signed'(i_coord[j]));
            b[j] = DW'(signed'(i_coord[3+j]));
            c[j] = DW'(signed'(i_coord[6+j]));
            p[j] = DW'(signed'(i_coord[9+j]));
            s1_v[0][j] = r1_n[j];
            s1_v[1][j] = r1_sa[j];
            s1_v[2][j] = r1_sb[j];
            s1_v[3][j] = r1_sc[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            for (int s = 1; s < NS; s++) begin
                if (en[s]) r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int j = 0; j < 3; j++) begin
                r0_ba[j] <= b[j] - a[j];
                r0_ca[j] <= c[j] - a[j];
                r0_pa[j] <= p[j] - a[j];
                r0_pb[j] <= p[j] - b[j];
                r0_pc[j] <= p[j] - c[j];
            end
        end
        if (en[1]) begin
            for (int j = 0; j < 3; j++) begin
                r1_n[j]  <= xprod(r0_ba[(j+1)%3], r0_ca[(j+2)%3],
                                  r0_ba[(j+2)%3], r0_ca[(j+1)%3]);
                r1_sa[j] <= xprod(r0_pb[(j+1)%3], r0_pc[(j+2)%3],
                                  r0_pb[(j+2)%3], r0_pc[(j+1)%3]);
                r1_sb[j] <= xprod(r0_pa[(j+1)%3], r0_ca[(j+2)%3],
                                  r0_pa[(j+2)%3], r0_ca[(j+1)%3]);
                r1_sc[j] <= xprod(r0_ba[(j+1)%3], r0_pa[(j+2)%3],
                                  r0_ba[(j+2)%3], r0_pa[(j+1)%3]);
            end
        end
        if (en[2]) begin
            r2_deg <= (r1_n[0] == '0) && (r1_n[1] == '0) && (r1_n[2] == '0);
            for (int d = 0; d < 4; d++) begin
                for (int j = 0; j < 3; j++) begin
                    r2_pp[d][j] <= part(r1_n[j], s1_v[d][j]);
                end
            end
        end
        if (en[3]) begin
            r3_deg <= r2_deg;
            for (int d = 0; d < 4; d++) begin
                for (int j = 0; j < 3; j++) begin
                    r3_cs[d][j] <= sum4(r2_pp[d][j]);
                end
            end
        end
        if (en[4]) begin
            r4_deg <= r3_deg;
            for (int d = 0; d < 4; d++) begin
                r4_dot[d] <= r3_cs[d][0] + r3_cs[d][1] + r3_cs[d][2];
            end
        end
        if (en[5]) begin
            r5_deg <= r4_deg;
            r5_nn  <= r4_dot[0];
            for (int w = 0; w < 3; w++) begin
                r5_neg[w] <= r4_dot[w+1][PW-1];
                r5_mag[w] <= r4_dot[w+1][PW-1] ? PW'(-r4_dot[w+1]) : r4_dot[w+1];
            end
        end
        if (en[6]) begin
            r6_deg <= r5_deg;
            r6_neg <= r5_neg;
            r6_div <= {r5_nn, 1'b0};
            for (int w = 0; w < 3; w++) begin
                r6_rem[w] <= (RW'(r5_mag[w]) << (WEIGHT_FRAC_BITS + 1)) + RW'(r5_nn);
            end
        end
    end

    assign o_en      = en[0];
    assign o_tag.vld = r_vld[NS-1];
    assign o_tag.deg = r6_deg;
    assign o_tag.neg = r6_neg;
    assign o_rem     = r6_rem;
    assign o_div     = r6_div;

endmodule

// ===== sv/bcc_div_cell.sv =====
// One restoring division cell: settles one quotient bit for all three weights.
`timescale 1ns / 1ps

module bcc_div_cell import bcc_pkg::*; #(
    parameter int RW    = 96,
    parameter int DVW   = 70,
    parameter int SHIFT = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_tag                        i_tag,
    input  logic [2:0][RW-1:0]          i_rem,
    input  logic [2:0][QUOT_BITS:0]     i_q,
    input  logic [DVW-1:0]              i_div,
    output logic                        o_en,
    input  logic                        i_next_en,
    output t_tag                        o_tag,
    output logic [2:0][RW-1:0]          o_rem,
    output logic [2:0][QUOT_BITS:0]     o_q,
    output logic [DVW-1:0]              o_div
);

    logic                    en;
    logic [RW-1:0]           sub;
    logic                    r_vld;
    t_tag                    r_tag;
    logic [2:0][RW-1:0]      r_rem;
    logic [2:0][QUOT_BITS:0] r_q;
    logic [DVW-1:0]          r_div;

    assign en  = !r_vld || i_next_en;
    assign sub = RW'(i_div) << SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= i_tag.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tag <= i_tag;
            r_div <= i_div;
            for (int w = 0; w < 3; w++) begin
                if (i_rem[w] >= sub) begin
                    r_rem[w] <= i_rem[w] - sub;
                    r_q[w]   <= i_q[w] | ((QUOT_BITS+1)'(1) << SHIFT);
                end else begin
                    r_rem[w] <= i_rem[w];
                    r_q[w]   <= i_q[w];
                end
            end
        end
    end

    assign o_en      = en;
    assign o_tag.vld = r_vld;
    assign o_tag.deg = r_tag.deg;
    assign o_tag.neg = r_tag.neg;
    assign o_rem     = r_rem;
    assign o_q       = r_q;
    assign o_div     = r_div;

endmodule
